FILE: hw/rtl/bscm_pkg.sv
// ----------------------------------------------------------------------------
// bscm_pkg
// Shared types and constants of the brush stroke coverage marker.
// ----------------------------------------------------------------------------
package bscm_pkg;

  localparam int CNT_W = 19;
  localparam logic [CNT_W-1:0] COUNT_MAX = 19'h7FFFF;

  // operand width of the step divider: deltas and stamp counts stay below 512
  localparam int DIV_W = 10;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_END   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_CANVAS_W = 2'd0,
    REG_CANVAS_H = 2'd1,
    REG_BRUSH    = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: hw/rtl/bscm_ram.sv
// ----------------------------------------------------------------------------
// bscm_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bscm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bscm_div.sv
// ----------------------------------------------------------------------------
// bscm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bscm_div import bscm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_e;

  dstate_e                      state_q;
  logic [$clog2(DIV_W)-1:0]     step_q;
  logic [DIV_W-1:0]             dvd_q;
  logic [DIV_W-1:0]             dvs_q;
  logic [DIV_W-1:0]             quo_q;
  logic [DIV_W-1:0]             rem_q;
  logic                         done_q;

  logic [DIV_W:0]               trial;
  logic                         fits;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      dvd_q   <= '0;
      dvs_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            dvd_q   <= req_i.dividend;
            dvs_q   <= req_i.divisor;
            quo_q   <= '0;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
          quo_q <= {quo_q[DIV_W-2:0], fits};
          rem_q <= fits ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
          if (step_q == ($clog2(DIV_W))'(DIV_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hw/rtl/brush_stroke_coverage_marker.sv
// ----------------------------------------------------------------------------
// brush_stroke_coverage_marker
// Stamps a square brush along strokes into a coverage bitmap and counts cells.
// ----------------------------------------------------------------------------
// end and ignored items answer in the cycle after acceptance; clear writes one
//   map word per cycle over the whole map (4096 words at defaults)
// a stamp: setup, base, a read and a write per map word touched in each row,
//   then next (an empty one: setup, then next); a move first runs the x and y divides, then n stamps
// one item at a time: busy stays high until its done strobe
// after reset a clearing pass over the whole map runs with busy high
// the receiver cannot stall: done is a single-cycle strobe
module brush_stroke_coverage_marker import bscm_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_STAMPS = 256,
  parameter int WORD_BITS  = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [8:0]       x_i,
  input  logic [8:0]       y_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [9:0]       cfg_wdata_i,
  output logic             done_o,
  output logic [CNT_W-1:0] covered_count_o,
  output logic             ignored_o
);

  // map words are a power of two wide and each row starts on a word
  localparam int LB    = $clog2(WORD_BITS + 1) - 1;
  localparam int LANE  = 1 << LB;
  localparam int WPR   = (MAX_WIDTH + LANE - 1) / LANE;
  localparam int DEPTH = MAX_HEIGHT * WPR;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLW   = $clog2(MAX_WIDTH + LANE + 1);
  localparam int RYW   = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = $clog2(MAX_WIDTH + MAX_HEIGHT + 1024) + 1;
  localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PCW   = LB + 1;
  localparam int OW    = (TW > CNT_W) ? TW : CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_SETUP,
    S_BASE,
    S_RD,
    S_WR,
    S_NEXT
  } state_e;

  state_e            state_q;
  logic              boot_q;
  logic [AW-1:0]     clr_q;
  logic [9:0]        cw_q, ch_q;
  logic [6:0]        bs_q;
  logic              active_q;
  logic [8:0]        px_q, py_q;
  logic [TW-1:0]     cnt_q;
  logic              done_q, ign_q;
  logic [8:0]        sx_q, sy_q;
  logic [9:0]        rx_q, ry_q;
  logic [9:0]        adx_q, ady_q;
  logic              negx_q, negy_q;
  logic [9:0]        n_q, i_q;
  logic signed [10:0] dqx_q, dqy_q;
  logic [9:0]        drx_q, dry_q;
  logic [CLW-1:0]    l_q, r_q, col_q;
  logic [RYW-1:0]    bot_q, top_q, row_q;
  logic [AW-1:0]     base_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [LANE-1:0]   ram_wdata, ram_rdata;

  logic              accept;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // move deltas
  logic signed [10:0] dx, dy;
  logic [9:0]         adx, ady, mlen;
  assign dx   = $signed({2'b00, x_i}) - $signed({2'b00, px_q});
  assign dy   = $signed({2'b00, y_i}) - $signed({2'b00, py_q});
  assign adx  = dx[10] ? 10'(-dx) : 10'(dx);
  assign ady  = dy[10] ? 10'(-dy) : 10'(dy);
  assign mlen = (adx > ady) ? adx : ady;

  // divider result turned into a floored signed step and its remainder
  logic              cur_neg;
  logic signed [10:0] q_s;
  logic signed [10:0] dq_fix;
  logic [9:0]        dr_fix;
  assign cur_neg = (state_q == S_DIVX_WAIT) ? negx_q : negy_q;
  assign q_s     = $signed({1'b0, div_rsp.quo});
  always_comb begin
    if (!cur_neg) begin
      dq_fix = q_s;
      dr_fix = div_rsp.rem;
    end else if (div_rsp.rem == '0) begin
      dq_fix = -q_s;
      dr_fix = '0;
    end else begin
      dq_fix = -q_s - 11'sd1;
      dr_fix = n_q - div_rsp.rem;
    end
  end

  assign div_req.start    = (state_q == S_DIVX_GO) || (state_q == S_DIVY_GO);
  assign div_req.dividend = (state_q == S_DIVX_GO) ? adx_q : ady_q;
  assign div_req.divisor  = n_q;

  // stamp rectangle, clamped to the canvas
  logic signed [SW-1:0] left, right, bottom, topy, lcl, rcl, bcl, tcl, wlim, hlim, half;
  logic                 rect_empty;
  always_comb begin
    half   = SW'(signed'({1'b0, bs_q >> 1}));
    wlim   = (32'(cw_q) < MAX_WIDTH) ? SW'(signed'({1'b0, cw_q})) : SW'(MAX_WIDTH);
    hlim   = (32'(ch_q) < MAX_HEIGHT) ? SW'(signed'({1'b0, ch_q})) : SW'(MAX_HEIGHT);
    left   = SW'(signed'({1'b0, sx_q})) - half;
    bottom = SW'(signed'({1'b0, sy_q})) - half;
    right  = left + SW'(signed'({1'b0, bs_q}));
    topy   = bottom + SW'(signed'({1'b0, bs_q}));
    lcl    = (left < 0) ? '0 : left;
    bcl    = (bottom < 0) ? '0 : bottom;
    rcl    = (right > wlim) ? wlim : right;
    tcl    = (topy > hlim) ? hlim : topy;
    rect_empty = (rcl <= lcl) || (tcl <= bcl);
  end

  // word segment of the current row
  logic [CLW-1:0]  cword, cbase, span, ncol;
  logic [PCW-1:0]  lo, hi, addc;
  logic [LANE-1:0] mask, newbits;
  logic [TW-1:0]   cnt_add;
  always_comb begin
    cword = col_q >> LB;
    cbase = CLW'(cword << LB);
    span  = r_q - cbase;
    lo    = PCW'(col_q - cbase);
    hi    = (span >= CLW'(LANE)) ? PCW'(LANE) : PCW'(span);
    for (int j = 0; j < LANE; j++) begin
      mask[j] = (PCW'(j) >= lo) && (PCW'(j) < hi);
    end
    newbits = mask & ~ram_rdata;
    addc    = PCW'($countones(newbits));
    cnt_add = cnt_q + TW'(addc);
    ncol    = CLW'((cword + CLW'(1)) << LB);
  end

  assign ram_we    = (state_q == S_CLR) || (state_q == S_WR);
  assign ram_addr  = (state_q == S_CLR) ? clr_q : AW'(base_q + AW'(cword));
  assign ram_wdata = (state_q == S_CLR) ? '0 : (ram_rdata | mask);

  // interpolation step
  logic [10:0]        rsx, rsy;
  logic               cx, cy;
  logic signed [11:0] nsx, nsy;
  always_comb begin
    rsx = {1'b0, rx_q} + {1'b0, drx_q};
    rsy = {1'b0, ry_q} + {1'b0, dry_q};
    cx  = rsx >= {1'b0, n_q};
    cy  = rsy >= {1'b0, n_q};
    nsx = $signed({3'b000, sx_q}) + 12'(dqx_q) + $signed({11'd0, cx});
    nsy = $signed({3'b000, sy_q}) + 12'(dqy_q) + $signed({11'd0, cy});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      boot_q   <= 1'b1;
      clr_q    <= '0;
      cw_q     <= 10'd512;
      ch_q     <= 10'd512;
      bs_q     <= 7'd7;
      active_q <= 1'b0;
      px_q     <= '0;
      py_q     <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      ign_q    <= 1'b0;
      sx_q     <= '0;
      sy_q     <= '0;
      rx_q     <= '0;
      ry_q     <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      negx_q   <= 1'b0;
      negy_q   <= 1'b0;
      n_q      <= '0;
      i_q      <= '0;
      dqx_q    <= '0;
      dqy_q    <= '0;
      drx_q    <= '0;
      dry_q    <= '0;
      l_q      <= '0;
      r_q      <= '0;
      col_q    <= '0;
      bot_q    <= '0;
      top_q    <= '0;
      row_q    <= '0;
      base_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_CANVAS_W: cw_q <= cfg_wdata_i;
          REG_CANVAS_H: ch_q <= cfg_wdata_i;
          REG_BRUSH:    bs_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ign_q <= 1'b0;
            rx_q  <= '0;
            ry_q  <= '0;
            i_q   <= '0;
            dqx_q <= '0;
            dqy_q <= '0;
            drx_q <= '0;
            dry_q <= '0;
            unique case (action_e'(action_i))
              ACT_BEGIN: begin
                if (active_q) begin
                  ign_q  <= 1'b1;
                  done_q <= 1'b1;
                end else begin
                  active_q <= 1'b1;
                  px_q     <= x_i;
                  py_q     <= y_i;
                  sx_q     <= x_i;
                  sy_q     <= y_i;
                  n_q      <= 10'd1;
                  state_q  <= S_SETUP;
                end
              end
              ACT_MOVE: begin
                if (!active_q) begin
                  ign_q  <= 1'b1;
                  done_q <= 1'b1;
                end else begin
                  px_q <= x_i;
                  py_q <= y_i;
                  if (mlen == '0) begin
                    sx_q    <= x_i;
                    sy_q    <= y_i;
                    n_q     <= 10'd1;
                    state_q <= S_SETUP;
                  end else begin
                    sx_q    <= px_q;
                    sy_q    <= py_q;
                    adx_q   <= adx;
                    ady_q   <= ady;
                    negx_q  <= dx[10];
                    negy_q  <= dy[10];
                    n_q     <= (32'(mlen) > MAX_STAMPS) ? 10'(MAX_STAMPS) : mlen;
                    state_q <= S_DIVX_GO;
                  end
                end
              end
              ACT_END: begin
                active_q <= 1'b0;
                done_q   <= 1'b1;
              end
              ACT_CLEAR: begin
                active_q <= 1'b0;
                cnt_q    <= '0;
                clr_q    <= '0;
                boot_q   <= 1'b0;
                state_q  <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          if (clr_q == AW'(DEPTH - 1)) begin
            done_q  <= !boot_q;
            boot_q  <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_DIVX_GO: state_q <= S_DIVX_WAIT;
        S_DIVX_WAIT: begin
          if (div_rsp.done) begin
            dqx_q   <= dq_fix;
            drx_q   <= dr_fix;
            state_q <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: state_q <= S_DIVY_WAIT;
        S_DIVY_WAIT: begin
          if (div_rsp.done) begin
            dqy_q   <= dq_fix;
            dry_q   <= dr_fix;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          l_q   <= CLW'(lcl);
          r_q   <= CLW'(rcl);
          bot_q <= RYW'(bcl);
          top_q <= RYW'(tcl);
          state_q <= rect_empty ? S_NEXT : S_BASE;
        end
        S_BASE: begin
          base_q  <= AW'(32'(bot_q) * WPR);
          row_q   <= bot_q;
          col_q   <= l_q;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          cnt_q <= cnt_add;
          if (ncol >= r_q) begin
            if (row_q + 1'b1 >= top_q) begin
              state_q <= S_NEXT;
            end else begin
              row_q   <= row_q + 1'b1;
              base_q  <= base_q + AW'(WPR);
              col_q   <= l_q;
              state_q <= S_RD;
            end
          end else begin
            col_q   <= ncol;
            state_q <= S_RD;
          end
        end
        S_NEXT: begin
          if (i_q + 10'd1 == n_q) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            i_q     <= i_q + 10'd1;
            rx_q    <= cx ? 10'(rsx - {1'b0, n_q}) : 10'(rsx);
            ry_q    <= cy ? 10'(rsy - {1'b0, n_q}) : 10'(rsy);
            sx_q    <= 9'(nsx);
            sy_q    <= 9'(nsy);
            state_q <= S_SETUP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  bscm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bscm_ram #(
    .WIDTH (LANE),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign ignored_o       = ign_q;
  assign covered_count_o = (OW'(cnt_q) > OW'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(cnt_q);

  // an accepted item either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted item neither started nor answered");

  // stamp index stays inside the planned stamp count while painting
  a_stamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (i_q < n_q))
    else $error("stamp index beyond stamp count");

  // the count only drops on an accepted clear
  a_count_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < $past(cnt_q)) |->
      $past(state_q == S_IDLE && start && action_i == ACT_CLEAR))
    else $error("covered count dropped without clear");

  // a result follows either an accept or a busy cycle
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result strobe without cause");

endmodule

FILE: dv/tb_brush_stroke_coverage_marker.sv
// ----------------------------------------------------------------------------
// tb_brush_stroke_coverage_marker
// Drives begin/move/end/clear items under several canvas and brush settings
// and checks every count and ignore flag against a cell-exact bitmap model.
// ----------------------------------------------------------------------------
class coverage_board;
  localparam int CW = 512;
  localparam int CH = 512;
  localparam int NSTAMP = 256;

  int unsigned canvas_w = 512;
  int unsigned canvas_h = 512;
  int unsigned brush = 7;
  bit cells [CW*CH];
  int unsigned covered;
  int prev_x, prev_y;
  bit active;
  logic [18:0] cnt_q [$];
  bit ign_q [$];
  int mismatches;
  int results;

  function void write_reg(bscm_pkg::reg_idx_e idx, logic [9:0] val);
    case (idx)
      bscm_pkg::REG_CANVAS_W: canvas_w = val;
      bscm_pkg::REG_CANVAS_H: canvas_h = val;
      bscm_pkg::REG_BRUSH:    brush = val[6:0];
      default: ;
    endcase
  endfunction

  function void stamp(int px, int py);
    int b, wl, hl, l, bt, r, t;
    b = brush;
    wl = canvas_w < CW ? canvas_w : CW;
    hl = canvas_h < CH ? canvas_h : CH;
    l = px - b / 2;
    bt = py - b / 2;
    r = l + b;
    t = bt + b;
    if (l < 0) l = 0;
    if (bt < 0) bt = 0;
    if (r > wl) r = wl;
    if (t > hl) t = hl;
    for (int row = bt; row < t; row++)
      for (int col = l; col < r; col++)
        if (!cells[row*CW+col]) begin
          cells[row*CW+col] = 1'b1;
          covered++;
        end
  endfunction

  function void note(bscm_pkg::action_e act, int x, int y);
    bit ign;
    int dx, dy, n;
    ign = 1'b0;
    case (act)
      bscm_pkg::ACT_BEGIN: begin
        if (active) ign = 1'b1;
        else begin
          active = 1'b1;
          prev_x = x;
          prev_y = y;
          stamp(x, y);
        end
      end
      bscm_pkg::ACT_MOVE: begin
        if (!active) ign = 1'b1;
        else begin
          dx = x - prev_x;
          dy = y - prev_y;
          n = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                        : (dy < 0 ? -dy : dy);
          if (n == 0) stamp(x, y);
          else begin
            if (n > NSTAMP) n = NSTAMP;
            // numerators stay non-negative, so integer division is a floor
            for (int i = 0; i < n; i++)
              stamp((prev_x * n + dx * i) / n, (prev_y * n + dy * i) / n);
            prev_x = x;
            prev_y = y;
          end
        end
      end
      bscm_pkg::ACT_END: active = 1'b0;
      default: begin
        foreach (cells[k]) cells[k] = 1'b0;
        covered = 0;
        active = 1'b0;
      end
    endcase
    cnt_q = {cnt_q, (covered > 19'h7FFFF) ? 19'h7FFFF : covered[18:0]};
    ign_q = {ign_q, ign};
  endfunction

  function void check(logic [18:0] cnt, logic ign);
    logic [18:0] e_cnt;
    bit e_ign;
    results++;
    if (cnt_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: count %0d ignored %0b", cnt, ign);
      return;
    end
    e_cnt = cnt_q.pop_front();
    e_ign = ign_q.pop_front();
    if (cnt !== e_cnt || ign !== e_ign) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: count exp %0d got %0d, ignored exp %0b got %0b",
                 e_cnt, cnt, e_ign, ign);
    end
  endfunction

  function int pending();
    return cnt_q.size();
  endfunction
endclass

module tb_brush_stroke_coverage_marker import bscm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic [8:0] x_i = '0;
  logic [8:0] y_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [9:0] cfg_wdata_i = '0;
  logic done_o;
  logic [CNT_W-1:0] covered_count_o;
  logic ignored_o;

  coverage_board board = new();
  int items_sent;
  int quiet_cycles;
  int px, py;

  brush_stroke_coverage_marker dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check(covered_count_o, ignored_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", board.pending());
      $display("[brush_stroke_coverage_marker] ERROR");
      $finish;
    end
  end

  // start stays high after acceptance; the next item either reuses it or drops it
  task automatic send(action_e act, int x, int y);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    x_i <= x[8:0];
    y_i <= y[8:0];
    do @(posedge clk_i); while (busy);
    board.note(act, x, y);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[9:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val[9:0]);
  endtask

  task automatic setup(int w, int h, int b);
    drain();
    write_reg(REG_CANVAS_W, w);
    write_reg(REG_CANVAS_H, h);
    write_reg(REG_BRUSH, b);
    write_reg(REG_NONE, $urandom_range(0, 1023));
  endtask

  // well-formed strokes with random content, plus some noise
  task automatic strokes(int count, int span);
    int k, d;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send(action_e'($urandom_range(0, 3)), $urandom_range(0, 511),
             $urandom_range(0, 511));
        k++;
      end else begin
        px = $urandom_range(0, 511);
        py = $urandom_range(0, 511);
        send(ACT_BEGIN, px, py);
        k++;
        repeat ($urandom_range(1, 4)) begin
          d = $urandom_range(0, 15) == 0 ? 511 : span;
          px = px + $urandom_range(0, 2*d) - d;
          py = py + $urandom_range(0, 2*d) - d;
          px = px < 0 ? 0 : (px > 511 ? 511 : px);
          py = py < 0 ? 0 : (py > 511 ? 511 : py);
          send(ACT_MOVE, px, py);
          k++;
        end
        send(ACT_END, 0, 0);
        k++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, full-length move, zero-length move, stroke-state cases
    send(ACT_BEGIN, 0, 0);
    send(ACT_BEGIN, 5, 5);
    send(ACT_MOVE, 511, 511);
    send(ACT_MOVE, 511, 511);
    send(ACT_END, 0, 0);
    send(ACT_END, 0, 0);
    send(ACT_MOVE, 100, 100);
    send(ACT_CLEAR, 0, 0);
    send(ACT_BEGIN, 511, 0);
    send(ACT_MOVE, 0, 511);
    send(ACT_MOVE, 3, 500);
    send(ACT_CLEAR, 0, 0);
    send(ACT_MOVE, 7, 7);
    send(ACT_BEGIN, 7, 7);
    send(ACT_END, 0, 0);

    // empty rectangles: zero brush and zero canvas
    setup(512, 512, 0);
    send(ACT_BEGIN, 20, 20);
    send(ACT_MOVE, 40, 30);
    send(ACT_END, 0, 0);
    setup(0, 512, 9);
    send(ACT_BEGIN, 20, 20);
    send(ACT_END, 0, 0);

    // shrunken canvas keeps earlier cells counted; enlarged one is clamped
    setup(100, 37, 1);
    strokes(18, 20);
    setup(1, 1, 64);
    strokes(12, 6);
    setup(1023, 1023, 127);
    strokes(8, 3);
    setup(512, 512, 7);
    strokes(20, 24);
    setup(300, 0, 5);
    strokes(6, 10);
    setup(511, 200, 3);
    strokes(22, 40);
    setup(512, 512, 2);
    strokes(19, 16);

    drain();
    $display("sent %0d items, %0d results checked over ten register settings",
             items_sent, board.results);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[brush_stroke_coverage_marker] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
      $display("[brush_stroke_coverage_marker] ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/bscm_pkg.sv
hw/rtl/bscm_ram.sv
hw/rtl/bscm_div.sv
hw/rtl/brush_stroke_coverage_marker.sv
dv/tb_brush_stroke_coverage_marker.sv
